FILE: rtl/core/ffra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit range allocator package
// Shared codes and constants for the allocator front end, queue and engine.
// ----------------------------------------------------------------------------
package ffra_pkg;

  // Request operation carried on the input sideband.
  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // Request class decided by the front end.
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SKIP    = 2'd2
  } kind_e;

  localparam int unsigned KIND_W = 2;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SPACE   = 2'd1,
    STAT_TABLE_FULL = 2'd2,
    STAT_UNDERFLOW  = 2'd3
  } status_e;

  // Engine sequencer states.
  typedef enum logic [1:0] {
    ENG_CLEAR  = 2'd0,
    ENG_IDLE   = 2'd1,
    ENG_SCAN   = 2'd2,
    ENG_COMMIT = 2'd3
  } eng_state_e;

  // Configuration register map.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_BASE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_SIZE = 1'b1;

  // Range size after reset: 2 GiB.
  localparam logic [63:0] RANGE_SIZE_RESET = 64'h0000_0000_8000_0000;

endpackage
`default_nettype wire

FILE: rtl/core/ffra_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts request words, rounds sizes up to pages and classifies each one.
// ----------------------------------------------------------------------------
module ffra_front import ffra_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 48,
  parameter int unsigned PAGE_SHIFT   = 12
) (
  input  logic                                 s_valid_i,
  output logic                                 s_ready_o,
  input  op_e                                  op_i,
  input  logic [ADDRESS_BITS-1:0]              addr_i,
  input  logic [ADDRESS_BITS:0]                size_i,
  input  logic                                 q_ready_i,
  input  logic                                 busy_i,
  output logic                                 push_o,
  output kind_e                                kind_o,
  output logic [ADDRESS_BITS-PAGE_SHIFT-1:0]   start_o,
  output logic [ADDRESS_BITS-PAGE_SHIFT+1:0]   pages_o
);

  localparam int unsigned SumW = ADDRESS_BITS + 2;

  logic [SumW-1:0] size_up;

  // Round up to whole pages; the extra bit keeps the carry of a full-range size.
  assign size_up = {1'b0, size_i} + SumW'((64'd1 << PAGE_SHIFT) - 64'd1);
  assign pages_o = size_up[SumW-1:PAGE_SHIFT];
  assign start_o = addr_i[ADDRESS_BITS-1:PAGE_SHIFT];

  always_comb begin
    if (op_i == OP_ALLOC) begin
      kind_o = KIND_ALLOC;
    end else if (pages_o == '0) begin
      kind_o = KIND_SKIP;
    end else begin
      kind_o = KIND_RELEASE;
    end
  end

  assign s_ready_o = q_ready_i && !busy_i;
  assign push_o    = s_valid_i && s_ready_o;

endmodule
`default_nettype wire

FILE: rtl/core/ffra_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator request queue
// Two-entry queue between the front end and the engine.
// ----------------------------------------------------------------------------
module ffra_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ffra_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator engine
// Holds the hole table in a single-port-read memory, scans it per request,
// commits the table update and usage count, and registers the result word.
// ----------------------------------------------------------------------------
module ffra_back import ffra_pkg::*; #(
  parameter int unsigned HOLE_SLOTS   = 64,
  parameter int unsigned PAGE_SHIFT   = 12,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]               cfg_index_i,
  input  logic [ADDRESS_BITS:0]                cfg_data_i,
  input  logic                                 item_valid_i,
  output logic                                 item_pop_o,
  input  kind_e                                item_kind_i,
  input  logic [ADDRESS_BITS-PAGE_SHIFT-1:0]   item_start_i,
  input  logic [ADDRESS_BITS-PAGE_SHIFT+1:0]   item_pages_i,
  output logic                                 busy_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ADDRESS_BITS-1:0]              out_granted_o,
  output status_e                              out_status_o,
  output logic [ADDRESS_BITS:0]                out_used_o
);

  localparam int unsigned SW   = ADDRESS_BITS - PAGE_SHIFT;
  localparam int unsigned LW   = SW + 1;
  localparam int unsigned PW   = SW + 2;
  localparam int unsigned SZW  = ADDRESS_BITS + 1;
  localparam int unsigned BW   = SZW + 1;
  localparam int unsigned EW   = 1 + SW + LW;
  localparam int unsigned IW   = $clog2(HOLE_SLOTS);
  localparam logic [IW-1:0] LastSlot = IW'(HOLE_SLOTS - 1);

  // Hole table: {valid, start page, length in pages}.
  logic [EW-1:0] mem [HOLE_SLOTS];
  logic [EW-1:0] rd_data_q;
  logic          rd_en;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  eng_state_e state_q, state_d;
  logic [ADDRESS_BITS-1:0] range_base_q;
  logic [SZW-1:0]          range_size_q;
  logic [SZW-1:0]          used_q, used_d;
  logic [IW-1:0]           clr_q, clr_d;
  logic [IW-1:0]           iss_q, iss_d;
  logic                    iss_done_q, iss_done_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [IW-1:0]           chk_idx_q, chk_idx_d;
  kind_e                   kind_q, kind_d;
  logic [SW-1:0]           start_q, start_d;
  logic [PW-1:0]           pages_q, pages_d;
  logic                    best_found_q, best_found_d;
  logic [IW-1:0]           best_idx_q, best_idx_d;
  logic [SW-1:0]           best_start_q, best_start_d;
  logic [LW-1:0]           best_len_q, best_len_d;
  logic                    free_found_q, free_found_d;
  logic [IW-1:0]           free_idx_q, free_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [ADDRESS_BITS-1:0] granted_q, granted_d;
  status_e                 status_q, status_d;
  logic [SZW-1:0]          out_used_q, out_used_d;

  logic          rd_valid;
  logic [SW-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic          fits, better, exact, underflow, saturate, cfg_hit, out_free;
  logic [BW-1:0] req_bytes;
  logic [SZW+1:0] used_sum;
  logic [SW-1:0] shrunk_start;
  logic [LW-1:0] shrunk_len;
  logic [SW-1:0] init_start;
  logic [LW-1:0] init_len;

  assign rd_valid = rd_data_q[EW-1];
  assign rd_start = rd_data_q[EW-2:LW];
  assign rd_len   = rd_data_q[LW-1:0];

  assign fits   = rd_valid && ({1'b0, rd_len} >= pages_q);
  assign better = !best_found_q || (rd_start < best_start_q);
  assign exact  = ({1'b0, best_len_q} == pages_q);

  assign req_bytes = {pages_q, {PAGE_SHIFT{1'b0}}};
  assign used_sum  = {2'b00, used_q} + {1'b0, req_bytes};
  assign saturate  = |used_sum[SZW+1:SZW];
  assign underflow = req_bytes > {1'b0, used_q};

  assign shrunk_start = best_start_q + pages_q[SW-1:0];
  assign shrunk_len   = best_len_q - pages_q[LW-1:0];

  assign init_start = range_base_q[ADDRESS_BITS-1:PAGE_SHIFT];
  assign init_len   = range_size_q[SZW-1:PAGE_SHIFT];

  assign cfg_hit  = cfg_we_i &&
                    (cfg_index_i == REG_RANGE_BASE || cfg_index_i == REG_RANGE_SIZE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    clr_d        = clr_q;
    iss_d        = iss_q;
    iss_done_d   = iss_done_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = iss_q;
    kind_d       = kind_q;
    start_d      = start_q;
    pages_d      = pages_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    granted_d    = granted_q;
    status_d     = status_q;
    out_used_d   = out_used_q;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = clr_q;
    mem_wd       = '0;
    item_pop_o   = 1'b0;

    case (state_q)
      ENG_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        if (clr_q == '0) begin
          mem_wd = {(init_len != '0), init_start, init_len};
        end
        if (clr_q == LastSlot) begin
          state_d = ENG_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ENG_IDLE: begin
        if (item_valid_i) begin
          item_pop_o   = 1'b1;
          kind_d       = item_kind_i;
          start_d      = item_start_i;
          pages_d      = item_pages_i;
          best_found_d = 1'b0;
          free_found_d = 1'b0;
          iss_d        = '0;
          iss_done_d   = 1'b0;
          state_d      = (item_kind_i == KIND_SKIP) ? ENG_COMMIT : ENG_SCAN;
        end
      end

      ENG_SCAN: begin
        if (!iss_done_q) begin
          rd_en     = 1'b1;
          chk_vld_d = 1'b1;
          if (iss_q == LastSlot) begin
            iss_done_d = 1'b1;
          end else begin
            iss_d = iss_q + 1'b1;
          end
        end
        if (chk_vld_q) begin
          // Strict compare keeps the lower slot on equal start pages.
          if (kind_q == KIND_ALLOC && fits && better) begin
            best_found_d = 1'b1;
            best_idx_d   = chk_idx_q;
            best_start_d = rd_start;
            best_len_d   = rd_len;
          end
          if (kind_q == KIND_RELEASE && !rd_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = chk_idx_q;
          end
          if (chk_idx_q == LastSlot) begin
            state_d = ENG_COMMIT;
          end
        end
      end

      ENG_COMMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          granted_d   = '0;
          status_d    = STAT_OK;
          state_d     = ENG_IDLE;
          case (kind_q)
            KIND_ALLOC: begin
              if (!best_found_q) begin
                status_d = STAT_NO_SPACE;
              end else begin
                granted_d = {best_start_q, {PAGE_SHIFT{1'b0}}};
                mem_we    = 1'b1;
                mem_wa    = best_idx_q;
                mem_wd    = exact ? '0 : {1'b1, shrunk_start, shrunk_len};
                used_d    = saturate ? '1 : used_sum[SZW-1:0];
              end
            end
            KIND_RELEASE: begin
              if (underflow) begin
                status_d = STAT_UNDERFLOW;
              end else if (!free_found_q) begin
                status_d = STAT_TABLE_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = free_idx_q;
                mem_wd = {1'b1, start_q, pages_q[LW-1:0]};
                used_d = used_q - req_bytes[SZW-1:0];
              end
            end
            default: begin
            end
          endcase
          out_used_d = used_d;
        end
      end

      default: begin
        state_d = ENG_CLEAR;
        clr_d   = '0;
      end
    endcase

    // A register write rebuilds the table from the new range.
    if (cfg_hit) begin
      state_d = ENG_CLEAR;
      clr_d   = '0;
      used_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ENG_CLEAR;
      range_base_q <= '0;
      range_size_q <= SZW'(RANGE_SIZE_RESET);
      used_q       <= '0;
      clr_q        <= '0;
      iss_q        <= '0;
      iss_done_q   <= 1'b0;
      chk_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      clr_q        <= clr_d;
      iss_q        <= iss_d;
      iss_done_q   <= iss_done_d;
      chk_vld_q    <= chk_vld_d;
      best_found_q <= best_found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i && cfg_index_i == REG_RANGE_BASE) begin
        range_base_q <= cfg_data_i[ADDRESS_BITS-1:0];
      end
      if (cfg_we_i && cfg_index_i == REG_RANGE_SIZE) begin
        range_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    kind_q       <= kind_d;
    start_q      <= start_d;
    pages_q      <= pages_d;
    best_idx_q   <= best_idx_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    free_idx_q   <= free_idx_d;
    granted_q    <= granted_d;
    status_q     <= status_d;
    out_used_q   <= out_used_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[iss_q];
    end
  end

  assign busy_o        = (state_q == ENG_CLEAR);
  assign out_valid_o   = out_valid_q;
  assign out_granted_o = granted_q;
  assign out_status_o  = status_q;
  assign out_used_o    = out_used_q;

endmodule
`default_nettype wire

FILE: rtl/core/first_fit_range_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit range allocator
// Hands out page-aligned pieces of one configured address range.
// ----------------------------------------------------------------------------
// An allocate or a nonzero release goes through these steps once the engine
// picks it up: it takes the request from the queue, reads the hole table one
// slot at a time through its single read port, checks each slot as its read
// returns, and writes back and registers the result once the output register
// is free. A zero-size release skips the scan. After reset and after every
// write of range_base or range_size the table is rebuilt one slot per cycle;
// s_axis_tready stays low during the rebuild. Requests and results are
// independent: the front end keeps accepting into a two-entry queue while
// the engine works, and a finished result waits in the output register
// without holding up the next scan.
module first_fit_range_allocator import ffra_pkg::*; #(
  parameter int unsigned HOLE_SLOTS   = 64,
  parameter int unsigned PAGE_SHIFT   = 12,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Request words.
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tuser: operation (0 allocate, 1 release).
  input  logic                                     s_axis_tuser,
  // tdata, from bit 0: release_address, size_bytes, zero fill.
  input  logic [((2*ADDRESS_BITS+1+7)/8)*8-1:0]    s_axis_tdata,
  // Result words.
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // tdata, from bit 0: granted_address, status, used_total, zero fill.
  output logic [((2*ADDRESS_BITS+3+7)/8)*8-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic                                     cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]                   cfg_index_i,
  input  logic [ADDRESS_BITS:0]                    cfg_data_i
);

  localparam int unsigned SW      = ADDRESS_BITS - PAGE_SHIFT;
  localparam int unsigned PW      = SW + 2;
  localparam int unsigned ItemW   = KIND_W + SW + PW;
  localparam int unsigned OutW    = ((2 * ADDRESS_BITS + 3 + 7) / 8) * 8;

  // Classified request from the front end.
  kind_e          fe_kind;
  logic [SW-1:0]  fe_start;
  logic [PW-1:0]  fe_pages;
  logic           fe_push;
  logic [ItemW-1:0] q_push_data;
  logic           q_ready;

  // Queue output towards the engine.
  logic           q_valid;
  logic           q_pop;
  logic [ItemW-1:0] q_pop_data;

  logic           eng_busy;

  // Engine result register.
  logic                    res_valid;
  logic [ADDRESS_BITS-1:0] res_granted;
  status_e                 res_status;
  logic [ADDRESS_BITS:0]   res_used;

  ffra_front #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .op_i      (op_e'(s_axis_tuser)),
    .addr_i    (s_axis_tdata[ADDRESS_BITS-1:0]),
    .size_i    (s_axis_tdata[2*ADDRESS_BITS:ADDRESS_BITS]),
    .q_ready_i (q_ready),
    .busy_i    (eng_busy),
    .push_o    (fe_push),
    .kind_o    (fe_kind),
    .start_o   (fe_start),
    .pages_o   (fe_pages)
  );

  // Queue entries are packed as {kind, start page, pages}.
  assign q_push_data = {fe_kind, fe_start, fe_pages};

  ffra_queue #(
    .WIDTH (ItemW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fe_push),
    .push_data_i  (q_push_data),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_pop_data)
  );

  ffra_back #(
    .HOLE_SLOTS   (HOLE_SLOTS),
    .PAGE_SHIFT   (PAGE_SHIFT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (q_valid),
    .item_pop_o    (q_pop),
    .item_kind_i   (kind_e'(q_pop_data[ItemW-1:SW+PW])),
    .item_start_i  (q_pop_data[SW+PW-1:PW]),
    .item_pages_i  (q_pop_data[PW-1:0]),
    .busy_o        (eng_busy),
    .out_valid_o   (res_valid),
    .out_ready_i   (m_axis_tready),
    .out_granted_o (res_granted),
    .out_status_o  (res_status),
    .out_used_o    (res_used)
  );

  // The result word comes straight from the engine's output register.
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = OutW'({res_used, res_status, res_granted});

  // A register write always starts the table rebuild, so no request may be
  // taken in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i == REG_RANGE_BASE || cfg_index_i == REG_RANGE_SIZE)
      |=> !s_axis_tready)
    else $error("request accepted right after a configuration write");

  // Only a successful allocate carries a nonzero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_granted != '0) |-> res_status == STAT_OK)
    else $error("granted address on a failed or release result");

  // The engine takes requests from the queue only after the rebuild is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !eng_busy && q_valid)
    else $error("queue popped during table rebuild");

endmodule
`default_nettype wire
